### rtl/core/rvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rvn_pkg;

  localparam int COMP_W    = 8;
  localparam int NORM_W    = 16;
  localparam int LEN_W     = 17;
  localparam int LANES     = 3;

  // Fraction bits of the normalized components; 2^FRAC_BITS means 1.0.
  localparam int FRAC_BITS = 15;
  // Fraction bits of the magnitude (Q9.8).
  localparam int MAG_FRAC  = 8;

  // Sum of squares and square root widths.
  localparam int SQ_W       = 2 * COMP_W + 2;
  localparam int ROOT_W     = (SQ_W + 2 * MAG_FRAC + 1) / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SREM_W     = ROOT_W + 2;

  // Divider: one quotient bit per stage.
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int DIV_PRE    = FRAC_BITS + MAG_FRAC - DIV_STEPS;

  // Squares stage, square-root stages, divide stages, output register.
  localparam int NUM_STAGES = 1 + SQRT_STEPS + DIV_STEPS + 1;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [NORM_W-1:0] norm_red;
    logic [NORM_W-1:0] norm_green;
    logic [NORM_W-1:0] norm_blue;
    logic [LEN_W-1:0]  length_q8;
    logic              is_null;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/rgb_vector_normalize.sv
`timescale 1ns / 1ps
`default_nettype none

// Normalizes an RGB pixel to unit length and reports its magnitude in Q9.8.
// Input channel: in_valid_i / in_stall_o with one pixel in in_data_i; an item
// is taken at a rising edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i with one result in out_data_o.
// Every pixel gives exactly one result, in order. A black pixel gives zero
// components and magnitude with is_null set.
// From the accepting edge to out_valid_o, an item passes the pipeline stages
// in order: one squares stage, one square-root bit per stage, one quotient
// bit per stage for all three components in parallel, and an output register.
// Throughput: one item per cycle while the receiver does not stall.
// When out_stall_i is high, the output holds and stages behind it keep
// advancing into empty slots; in_stall_o rises only once every stage from
// the input to the output holds an item.
// Reset empties the pipeline; no result is pending after reset.
module rgb_vector_normalize (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire rvn_pkg::pixel_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output rvn_pkg::result_t     out_data_o
);

  import rvn_pkg::*;

  localparam int OUT_STG = NUM_STAGES - 1;
  localparam logic [DIV_STEPS-1:0] QUO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Stage valid bits and per-stage hold
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] v_d;
  logic [NUM_STAGES-1:0] v_up;
  logic [NUM_STAGES-1:0] hold;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_hold
    assign hold[i] = out_stall_i & (&v_q[NUM_STAGES-1:i]);
  end

  assign v_up = {v_q[NUM_STAGES-2:0], in_valid_i};
  assign v_d  = (v_q & hold) | (v_up & ~hold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o = hold[0];

  // Squares stage
  logic [2*COMP_W-1:0] rr;
  logic [2*COMP_W-1:0] gg;
  logic [2*COMP_W-1:0] bb;
  logic [SQ_W-1:0]     sq_d;
  logic [SQ_W-1:0]     sq_q;
  pixel_t              pix0_q;

  assign rr   = in_data_i.red * in_data_i.red;
  assign gg   = in_data_i.green * in_data_i.green;
  assign bb   = in_data_i.blue * in_data_i.blue;
  assign sq_d = SQ_W'(rr) + SQ_W'(gg) + SQ_W'(bb);

  always_ff @(posedge clk_i) begin
    if (!hold[0]) begin
      pix0_q <= in_data_i;
      sq_q   <= sq_d;
    end
  end

  // Square root of sq << (2*MAG_FRAC), one result bit per stage
  logic [SREM_W-1:0] srem_q [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [SQRT_STEPS];
  logic [SQ_W-1:0]   ssq_q  [SQRT_STEPS];
  pixel_t            spix_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int STG     = 1 + k;
    localparam int PAIR_LO = 2 * (SQRT_STEPS - 1 - k) - 2 * MAG_FRAC;

    logic [SREM_W-1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   sq_in;
    pixel_t            pix_in;
    logic [1:0]        pair;
    logic [SREM_W+1:0] rem_t;
    logic [SREM_W+1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sq_in   = sq_q;
      assign pix_in  = pix0_q;
    end else begin : g_next
      assign rem_in  = srem_q[k-1];
      assign root_in = root_q[k-1];
      assign sq_in   = ssq_q[k-1];
      assign pix_in  = spix_q[k-1];
    end

    // Bit pairs below the Q8 shift are zero.
    if (PAIR_LO >= 0) begin : g_pair
      assign pair = sq_in[PAIR_LO+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_t = {rem_in, pair};
    assign trial = {{(SREM_W - ROOT_W){1'b0}}, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (!hold[STG]) begin
        ssq_q[k]  <= sq_in;
        spix_q[k] <= pix_in;
        if (rem_t >= trial) begin
          srem_q[k] <= SREM_W'(rem_t - trial);
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          srem_q[k] <= SREM_W'(rem_t);
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Division c << (FRAC_BITS+MAG_FRAC) / magnitude, one quotient bit per stage.
  // The magnitude is at least c << MAG_FRAC, so the quotient fits DIV_STEPS bits.
  logic [LANES-1:0][ROOT_W-1:0]    drem_q [DIV_STEPS];
  logic [LANES-1:0][DIV_STEPS-1:0] quo_q  [DIV_STEPS];
  logic [ROOT_W-1:0]               mag_q  [DIV_STEPS];
  logic [LANES-1:0][COMP_W-1:0]    comp;

  assign comp[0] = spix_q[SQRT_STEPS-1].red;
  assign comp[1] = spix_q[SQRT_STEPS-1].green;
  assign comp[2] = spix_q[SQRT_STEPS-1].blue;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int STG = 1 + SQRT_STEPS + k;

    logic [ROOT_W-1:0] mag_in;

    if (k == 0) begin : g_mag_first
      assign mag_in = root_q[SQRT_STEPS-1];
    end else begin : g_mag_next
      assign mag_in = mag_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (!hold[STG]) begin
        mag_q[k] <= mag_in;
      end
    end

    for (genvar ch = 0; ch < LANES; ch++) begin : g_lane
      logic [ROOT_W-1:0]    rem_in;
      logic [DIV_STEPS-1:0] quo_in;
      logic [ROOT_W:0]      sh;
      logic [ROOT_W:0]      dsr;

      if (k == 0) begin : g_first
        assign rem_in = ROOT_W'(comp[ch]) << DIV_PRE;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = drem_q[k-1][ch];
        assign quo_in = quo_q[k-1][ch];
      end

      assign sh  = {rem_in, 1'b0};
      assign dsr = {1'b0, mag_in};

      always_ff @(posedge clk_i) begin
        if (!hold[STG]) begin
          if (sh >= dsr) begin
            drem_q[k][ch] <= ROOT_W'(sh - dsr);
            quo_q[k][ch]  <= {quo_in[DIV_STEPS-2:0], 1'b1};
          end else begin
            drem_q[k][ch] <= ROOT_W'(sh);
            quo_q[k][ch]  <= {quo_in[DIV_STEPS-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Output register: saturate, mask, and zero out a black pixel
  logic [LANES-1:0][NORM_W-1:0] norm;
  logic                         null_w;
  result_t                      res_d;
  result_t                      res_q;

  for (genvar ch = 0; ch < LANES; ch++) begin : g_sat
    assign norm[ch] = (quo_q[DIV_STEPS-1][ch] > QUO_ONE) ? NORM_W'(QUO_ONE)
                                                         : NORM_W'(quo_q[DIV_STEPS-1][ch]);
  end

  assign null_w = (mag_q[DIV_STEPS-1] == '0);

  always_comb begin
    res_d.norm_red   = norm[0];
    res_d.norm_green = norm[1];
    res_d.norm_blue  = norm[2];
    res_d.length_q8  = LEN_W'(mag_q[DIV_STEPS-1]);
    res_d.is_null    = null_w;
    if (null_w) begin
      res_d.norm_red   = '0;
      res_d.norm_green = '0;
      res_d.norm_blue  = '0;
      res_d.length_q8  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold[OUT_STG]) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v_q[OUT_STG];
  assign out_data_o  = res_q;

  // Input backs up only when every stage is full and the output is stalled.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && (&v_q)))
    else $error("input stalled while the pipeline has room");

  // Square-root remainder never exceeds twice the root.
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[SQRT_STEPS] |->
      (srem_q[SQRT_STEPS-1] <= {1'b0, root_q[SQRT_STEPS-1], 1'b0}))
    else $error("square-root remainder out of range");

  // Division remainders stay below the divisor.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[OUT_STG-1] && (mag_q[DIV_STEPS-1] != '0)) |->
      ((drem_q[DIV_STEPS-1][0] < mag_q[DIV_STEPS-1]) &&
       (drem_q[DIV_STEPS-1][1] < mag_q[DIV_STEPS-1]) &&
       (drem_q[DIV_STEPS-1][2] < mag_q[DIV_STEPS-1])))
    else $error("divider remainder not below magnitude");

  // A black pixel gives an all-zero result.
  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_null) |->
      ((out_data_o.norm_red == '0) && (out_data_o.norm_green == '0) &&
       (out_data_o.norm_blue == '0) && (out_data_o.length_q8 == '0)))
    else $error("black pixel with nonzero result");

  // A nonzero pixel never normalizes above 1.0.
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.is_null) |->
      ((out_data_o.length_q8 != '0) &&
       (out_data_o.norm_red <= NORM_W'(QUO_ONE)) &&
       (out_data_o.norm_green <= NORM_W'(QUO_ONE)) &&
       (out_data_o.norm_blue <= NORM_W'(QUO_ONE))))
    else $error("normalized component out of range");

endmodule

`default_nettype wire

### tb/rgb_vector_normalize_tb.sv
`timescale 1ns / 1ps

module rgb_vector_normalize_tb;
  import rvn_pkg::*;

  localparam int LATENCY     = SQRT_STEPS + DIV_STEPS + 1;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_LIMIT = IDLE_LIMIT / 2;
  localparam int IDLE_PCT    = 12;

  typedef struct {
    pixel_t  px;
    bit      has_want;
    result_t want;
  } pixel_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_stall_o;
  pixel_t  in_data_i;
  logic    out_valid_o;
  logic    out_stall_i;
  result_t out_data_o;

  result_t    pending_results [$];
  pixel_row_t directed_rows [$];
  result_t    got;
  result_t    want;
  int         mismatches  = 0;
  int         idle_cycles = 0;
  int         result_idx  = 0;
  bit         steady      = 1'b0;
  bit         hold_req    = 1'b0;

  rgb_vector_normalize dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [NORM_W-1:0] scale_lane(input logic [COMP_W-1:0] c,
                                                   input logic [63:0] mag);
    logic [63:0] quot;
    quot = (64'(c) << (FRAC_BITS + MAG_FRAC)) / mag;
    if (quot > (64'd1 << FRAC_BITS)) begin
      quot = 64'd1 << FRAC_BITS;
    end
    return quot[NORM_W-1:0];
  endfunction

  function automatic result_t normalized_pixel(input pixel_t px);
    logic [63:0] sum_sq;
    logic [63:0] scaled;
    logic [63:0] root;
    logic [63:0] cand;
    result_t     res;
    sum_sq = 64'(px.red) * 64'(px.red) + 64'(px.green) * 64'(px.green)
           + 64'(px.blue) * 64'(px.blue);
    scaled = sum_sq << (2 * MAG_FRAC);
    // Build the floor square root one bit at a time from the top.
    root = '0;
    for (int i = 24; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= scaled) begin
        root = cand;
      end
    end
    res = '0;
    if (root == 0) begin
      res.is_null = 1'b1;
    end else begin
      res.norm_red   = scale_lane(px.red, root);
      res.norm_green = scale_lane(px.green, root);
      res.norm_blue  = scale_lane(px.blue, root);
      res.length_q8  = root[LEN_W-1:0];
    end
    return res;
  endfunction

  function automatic pixel_row_t plain_row(input int r, input int g, input int b);
    pixel_row_t row;
    row.px       = '{red: COMP_W'(r), green: COMP_W'(g), blue: COMP_W'(b)};
    row.has_want = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  function automatic pixel_row_t known_row(input int r, input int g, input int b,
                                           input int nr, input int ng, input int nb,
                                           input int len, input bit nul);
    pixel_row_t row;
    row                 = plain_row(r, g, b);
    row.has_want        = 1'b1;
    row.want.norm_red   = NORM_W'(nr);
    row.want.norm_green = NORM_W'(ng);
    row.want.norm_blue  = NORM_W'(nb);
    row.want.length_q8  = LEN_W'(len);
    row.want.is_null    = nul;
    return row;
  endfunction

  function automatic logic [COMP_W-1:0] pick_component(input int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? COMP_W'($urandom_range(0, 3)) : '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return COMP_W'(1);
          2: return COMP_W'(254);
          default: return '1;
        endcase
      end
      default: return COMP_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int idx,
                             input logic [63:0] have, input logic [63:0] need);
    if (have !== need) begin
      report_mismatch($sformatf("result %0d %s got %0d want %0d", idx, name, have, need));
    end
  endtask

  // Offer one pixel and hold it until the block takes it.
  task automatic send_pixel(input pixel_t px, input result_t expected);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    pending_results.push_back(expected);
  endtask

  task automatic send_random(input int count);
    pixel_t px;
    int     mode;
    repeat (count) begin
      mode     = $urandom_range(0, 9);
      px.red   = pick_component(mode);
      px.green = pick_component(mode);
      px.blue  = pick_component(mode);
      send_pixel(px, normalized_pixel(px));
    end
  endtask

  // Receiver: random stalls, or one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Sample at the falling edge; a handshake seen here completes at the next rise.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_data_o;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", result_idx));
      end else begin
        want = pending_results.pop_front();
        check_field("norm_red", result_idx, got.norm_red, want.norm_red);
        check_field("norm_green", result_idx, got.norm_green, want.norm_green);
        check_field("norm_blue", result_idx, got.norm_blue, want.norm_blue);
        check_field("length_q8", result_idx, got.length_q8, want.length_q8);
        check_field("is_null", result_idx, got.is_null, want.is_null);
      end
      result_idx++;
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;

    // Black pixel, pure axes at full and unit scale, half-scale red, then mixed colors and a last black pixel.
    directed_rows.push_back(known_row(0, 0, 0, 0, 0, 0, 0, 1'b1));
    directed_rows.push_back(known_row(255, 0, 0, 32768, 0, 0, 65280, 1'b0));
    directed_rows.push_back(known_row(0, 255, 0, 0, 32768, 0, 65280, 1'b0));
    directed_rows.push_back(known_row(0, 0, 255, 0, 0, 32768, 65280, 1'b0));
    directed_rows.push_back(known_row(1, 0, 0, 32768, 0, 0, 256, 1'b0));
    directed_rows.push_back(known_row(0, 1, 0, 0, 32768, 0, 256, 1'b0));
    directed_rows.push_back(known_row(0, 0, 1, 0, 0, 32768, 256, 1'b0));
    directed_rows.push_back(known_row(128, 0, 0, 32768, 0, 0, 32768, 1'b0));
    directed_rows.push_back(plain_row(255, 255, 255));
    directed_rows.push_back(plain_row(1, 1, 1));
    directed_rows.push_back(plain_row(1, 1, 0));
    // Near-axis pixels sit closest to the saturation bound.
    directed_rows.push_back(plain_row(255, 1, 0));
    directed_rows.push_back(plain_row(1, 255, 1));
    directed_rows.push_back(plain_row(0, 1, 255));
    directed_rows.push_back(plain_row(255, 255, 0));
    directed_rows.push_back(plain_row(0, 255, 255));
    directed_rows.push_back(plain_row(3, 4, 0));
    directed_rows.push_back(plain_row(170, 85, 51));
    directed_rows.push_back(plain_row(85, 170, 204));
    directed_rows.push_back(plain_row(254, 254, 254));
    directed_rows.push_back(plain_row(128, 128, 128));
    directed_rows.push_back(plain_row(200, 100, 50));
    directed_rows.push_back(known_row(0, 0, 0, 0, 0, 0, 0, 1'b1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].px, directed_rows[i].has_want ?
                 directed_rows[i].want : normalized_pixel(directed_rows[i].px));
    end

    send_random(500);

    steady = 1'b1;
    send_random(300);

    // Keep offering while the output is held so the pipeline backs up.
    hold_req = 1'b1;
    send_random(150);
    steady = 1'b0;

    // Pause the sender until the pipeline drains.
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    send_random(480);
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0 && idle_cycles < DRAIN_LIMIT) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rvn_pkg.sv
rtl/core/rgb_vector_normalize.sv
tb/rgb_vector_normalize_tb.sv
